/* design/random_hyperplane_signature_top_assert.svh */
// Assertion macros for the random hyperplane signature block.
`ifndef RANDOM_HYPERPLANE_SIGNATURE_TOP_ASSERT_SVH
`define RANDOM_HYPERPLANE_SIGNATURE_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define RHS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rhs assertion failed");
// Next-cycle implication, checked out of reset.
`define RHS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rhs assertion failed");
`else
`define RHS_ASSERT_IMPL(lbl, ante, cons)
`define RHS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* design/rhs_pkg.sv */
// Shared constants and types for the random hyperplane signature block.
`default_nettype none
package rhs_pkg;
  localparam int PLANES  = 16;
  localparam int DIM     = 64;
  localparam int PLANE_W = 4;
  localparam int ELEM_W  = $clog2(DIM);
  localparam int POS_W   = $clog2(DIM + 1);
  localparam int VAL_W   = 16;
  localparam int PROD_W  = 2 * VAL_W;
  localparam int SUM_W   = 40;
  localparam int SIG_W   = 16;

  localparam logic [POS_W-1:0] DIM_POS = POS_W'(DIM);

  // Input op codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_FEATURE = 1'b1;

  // Per-stage control that travels with one feature beat
  typedef struct packed {
    logic valid;  // feature beat present
    logic acc;    // sample position below DIM
    logic last;   // final sample of the vector
    logic ovr;    // overrun seen up to and including this beat
  } rhs_ctl_t;
endpackage
`default_nettype wire

/* design/rhs_coef_lane.sv */
// Coefficient store for one hyperplane: DIM entries, one write and one registered read.
`default_nettype none
module rhs_coef_lane (
  input  wire logic                       clk,
  input  wire logic                       wr_en,
  input  wire logic [rhs_pkg::ELEM_W-1:0] wr_addr,
  input  wire logic [rhs_pkg::VAL_W-1:0]  wr_data,
  input  wire logic                       rd_en,
  input  wire logic [rhs_pkg::ELEM_W-1:0] rd_addr,
  output logic      [rhs_pkg::VAL_W-1:0]  rd_data
);
  import rhs_pkg::*;

  logic [VAL_W-1:0] mem [DIM];
  logic [VAL_W-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

/* design/rhs_mac_lane.sv */
// Multiply-accumulate lane: product register and 40-bit running sum for one hyperplane.
`default_nettype none
module rhs_mac_lane (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire rhs_pkg::rhs_ctl_t         ctl1,
  input  wire rhs_pkg::rhs_ctl_t         ctl2,
  input  wire logic [rhs_pkg::VAL_W-1:0] sample,
  input  wire logic [rhs_pkg::VAL_W-1:0] coef,
  output logic                           nonneg
);
  import rhs_pkg::*;

  logic [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;

  // Product stage
  always_ff @(posedge clk) begin
    if (ctl1.valid && ctl1.acc) begin
      prod_r <= PROD_W'($signed(sample) * $signed(coef));
    end
  end

  // Accumulate, sign-extending the product
  always_comb begin
    sum_nxt = sum_r;
    if (ctl2.valid && ctl2.acc) begin
      sum_nxt = sum_r + {{(SUM_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  // Sum clears once the vector's last beat is folded in
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl2.valid && ctl2.last) begin
      sum_r <= '0;
    end else begin
      sum_r <= sum_nxt;
    end
  end

  assign nonneg = ~sum_nxt[SUM_W-1];
endmodule
`default_nettype wire

/* design/random_hyperplane_signature_top.sv */
// Top level of the random hyperplane signature block.
// Usage:
//   An input beat is taken at each clock edge with start high and busy low;
//   busy is always low, so one beat per cycle is accepted.
//   in_op = load writes in_sample_value as the coefficient of hyperplane
//   in_plane_index at position in_element_index. in_op = feature feeds the
//   next vector sample into all PLANES multiply-accumulate lanes in parallel.
//   A feature beat with in_last set closes the vector: after it passes ctl1_r
//   and ctl2_r, out_valid is registered high for one cycle with out_signature (bit j set
//   when sum j is >= 0) and out_overrun (vector longer than DIM samples).
//   Sums, position and overrun flag then restart from zero.
// Timing: one beat per cycle sustained; the path is coefficient read, product
//   register, accumulate and result register.
// Reset: synchronous active-low rst_n clears sums, position, overrun flag and
//   the pipeline control. Coefficients are not cleared and must be loaded before use.
// The receiver cannot stall: each result beat is shown for one cycle only.
`default_nettype none
module random_hyperplane_signature_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_op,
  input  wire logic [rhs_pkg::PLANE_W-1:0] in_plane_index,
  input  wire logic [rhs_pkg::ELEM_W-1:0]  in_element_index,
  input  wire logic [rhs_pkg::VAL_W-1:0]   in_sample_value,
  input  wire logic                        in_last,
  output logic                             out_valid,
  output logic [rhs_pkg::SIG_W-1:0]        out_signature,
  output logic                             out_overrun
);
  import rhs_pkg::*;

  logic             accept;
  logic             feat_acc;
  logic             load_ok;
  logic             in_range;
  logic [POS_W-1:0] pos_r;
  logic [POS_W-1:0] pos_nxt;
  logic             ovf_r;
  logic             ovf_nxt;
  rhs_ctl_t         ctl1_r;
  rhs_ctl_t         ctl1_nxt;
  rhs_ctl_t         ctl2_r;
  logic [VAL_W-1:0] sample1_r;
  logic [VAL_W-1:0] coef   [PLANES];
  logic [PLANES-1:0] nonneg;
  logic [SIG_W-1:0]  sig_nxt;
  logic              out_valid_r;
  logic [SIG_W-1:0]  signature_r;
  logic              overrun_r;

  assign busy     = 1'b0;
  assign accept   = start && !busy;
  assign feat_acc = accept && (in_op == OP_FEATURE);
  assign in_range = (pos_r < DIM_POS);
  assign load_ok  = accept && (in_op == OP_LOAD) && (int'(in_element_index) < DIM);

  // Vector position and overrun tracking
  always_comb begin
    pos_nxt        = pos_r;
    ovf_nxt        = ovf_r;
    ctl1_nxt.valid = feat_acc;
    ctl1_nxt.acc   = in_range;
    ctl1_nxt.last  = in_last;
    ctl1_nxt.ovr   = ovf_r || !in_range;
    if (feat_acc) begin
      if (in_last) begin
        pos_nxt = '0;
        ovf_nxt = 1'b0;
      end else if (in_range) begin
        pos_nxt = pos_r + POS_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      ovf_r  <= 1'b0;
      ctl1_r <= '0;
      ctl2_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      ovf_r  <= ovf_nxt;
      ctl1_r <= ctl1_nxt;
      ctl2_r <= ctl1_r;
    end
  end

  // Sample rides alongside the coefficient read
  always_ff @(posedge clk) begin
    if (feat_acc) begin
      sample1_r <= in_sample_value;
    end
  end

  // One coefficient store and one MAC per hyperplane
  for (genvar p = 0; p < PLANES; p++) begin : g_lane
    rhs_coef_lane u_coef (
      .clk     (clk),
      .wr_en   (load_ok && (int'(in_plane_index) == p)),
      .wr_addr (in_element_index),
      .wr_data (in_sample_value),
      .rd_en   (feat_acc && in_range),
      .rd_addr (pos_r[ELEM_W-1:0]),
      .rd_data (coef[p])
    );

    rhs_mac_lane u_mac (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl1   (ctl1_r),
      .ctl2   (ctl2_r),
      .sample (sample1_r),
      .coef   (coef[p]),
      .nonneg (nonneg[p])
    );
  end

  // Signature bits; planes beyond the reported width are dropped
  always_comb begin
    sig_nxt = '0;
    for (int j = 0; j < SIG_W; j++) begin
      if (j < PLANES) begin
        sig_nxt[j] = nonneg[j];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl2_r.valid && ctl2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl2_r.valid && ctl2_r.last) begin
      signature_r <= sig_nxt;
      overrun_r   <= ctl2_r.ovr;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_signature = signature_r;
  assign out_overrun   = overrun_r;

`include "random_hyperplane_signature_top_assert.svh"

  `RHS_ASSERT_IMPL(a_last_gives_result, feat_acc && in_last, ##3 out_valid)
  `RHS_ASSERT_IMPL(a_result_has_cause, out_valid, $past(feat_acc && in_last, 3))
  `RHS_ASSERT_NEXT(a_last_restarts, feat_acc && in_last, pos_r == '0 && !ovf_r)
  `RHS_ASSERT_IMPL(a_pos_bounded, 1'b1, pos_r <= DIM_POS)
endmodule
`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the random hyperplane signature block.
module tb_top;
  import rhs_pkg::*;

  // One expected signature beat
  typedef struct {
    logic [SIG_W-1:0] sig;
    logic             ovr;
  } signature_t;

  // Tracks coefficients, running dot products and the signatures still owed
  class signature_scoreboard;
    shortint    coef [PLANES][DIM];
    longint     dot_sum [PLANES];
    int         position;
    bit         overrun_seen;
    signature_t pending [$];
    int         errors;

    function new();
      clear_vector();
      errors = 0;
    endfunction

    function void clear_vector();
      foreach (dot_sum[p]) dot_sum[p] = 0;
      position     = 0;
      overrun_seen = 1'b0;
    endfunction

    // Apply one accepted input beat; a closing feature beat owes a signature
    function void note_beat(logic op, logic [PLANE_W-1:0] plane,
                            logic [ELEM_W-1:0] elem, logic [VAL_W-1:0] value,
                            logic last);
      signature_t want;
      if (op == OP_LOAD) begin
        if (plane < PLANES && elem < DIM) coef[plane][elem] = shortint'(value);
        return;
      end
      if (position < DIM) begin
        for (int p = 0; p < PLANES; p++)
          dot_sum[p] += longint'(shortint'(value)) * longint'(coef[p][position]);
        position++;
      end else begin
        overrun_seen = 1'b1;
      end
      if (last) begin
        want.sig = '0;
        for (int p = 0; p < PLANES && p < SIG_W; p++)
          if (dot_sum[p] >= 0) want.sig[p] = 1'b1;
        want.ovr = overrun_seen;
        pending = {pending, want};
        clear_vector();
      end
    endfunction

    // Compare one result beat against the oldest expectation
    function void check_signature(logic [SIG_W-1:0] sig, logic ovr);
      signature_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, signature %h overrun %b", $time, sig, ovr);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want.sig !== sig) begin
        $display("%0t: signature expected %h actual %h", $time, want.sig, sig);
        errors++;
      end
      if (want.ovr !== ovr) begin
        $display("%0t: overrun expected %b actual %b", $time, want.ovr, ovr);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_op;
  logic [PLANE_W-1:0] in_plane_index;
  logic [ELEM_W-1:0]  in_element_index;
  logic [VAL_W-1:0]   in_sample_value;
  logic               in_last;
  logic               out_valid;
  logic [SIG_W-1:0]   out_signature;
  logic               out_overrun;

  signature_scoreboard sb = new();
  int beats_sent = 0;

  random_hyperplane_signature_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_plane_index   (in_plane_index),
    .in_element_index (in_element_index),
    .in_sample_value  (in_sample_value),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_signature    (out_signature),
    .out_overrun      (out_overrun)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Results are sampled mid-cycle, away from the driving edge
  always @(negedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_signature(out_signature, out_overrun);
  end

  // Values biased toward the Q1.15 extremes, zero and all ones (minus one as an integer)
  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return '0;
      3: return 16'hFFFF;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Drive one beat and hold it until the block takes it; called at a rising edge
  task automatic send_beat(input logic op, input logic [PLANE_W-1:0] plane,
                           input logic [ELEM_W-1:0] elem,
                           input logic [VAL_W-1:0] value, input logic last);
    in_op            <= op;
    in_plane_index   <= plane;
    in_element_index <= elem;
    in_sample_value  <= value;
    in_last          <= last;
    start            <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    sb.note_beat(op, plane, elem, value, last);
    beats_sent++;
  endtask

  task automatic send_feature(input logic [VAL_W-1:0] value, input logic last);
    send_beat(OP_FEATURE, '0, '0, value, last);
  endtask

  task automatic send_random_load();
    send_beat(OP_LOAD, PLANE_W'($urandom_range(0, PLANES - 1)),
              ELEM_W'($urandom_range(0, DIM - 1)), rand_value(), 1'($urandom));
  endtask

  task automatic idle_burst(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Random sender gaps, switched off near the end of the run
  task automatic maybe_idle(input int progress);
    if (progress < 650 && $urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 6));
  endtask

  // Stop sending until every owed signature has come back
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < 1000 && sb.pending.size() != 0; i++) @(posedge clk);
  endtask

  initial begin
    int rand_start;
    int vectors;
    int len;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_op            <= OP_LOAD;
    in_plane_index   <= '0;
    in_element_index <= '0;
    in_sample_value  <= '0;
    in_last          <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every coefficient before any feature beat reads one
    for (int p = 0; p < PLANES; p++)
      for (int e = 0; e < DIM; e++)
        send_beat(OP_LOAD, PLANE_W'(p), ELEM_W'(e), rand_value(), 1'($urandom));

    // Directed: extreme coefficients, last on a load, extreme indices
    send_beat(OP_LOAD, 4'd0, 6'd0, 16'h8000, 1'b1);
    send_beat(OP_LOAD, 4'd1, 6'd0, 16'h7FFF, 1'b0);
    send_beat(OP_LOAD, 4'd2, 6'd0, 16'h0000, 1'b0);
    send_beat(OP_LOAD, 4'd15, 6'd63, 16'h7FFF, 1'b1);
    send_beat(OP_LOAD, 4'd3, 6'd0, 16'hFFFF, 1'b0);
    // mostly single-sample vectors, one of two samples; a zero sample leaves every sum at zero
    send_feature(16'h8000, 1'b1);
    send_feature(16'h0000, 1'b1);
    send_feature(16'h7FFF, 1'b0);
    send_feature(16'h8000, 1'b1);
    send_feature(16'h0001, 1'b1);
    send_feature(16'hFFFF, 1'b1);
    // reload a coefficient just ahead of the sample that uses it
    send_beat(OP_LOAD, 4'd0, 6'd1, 16'h8000, 1'b0);
    send_feature(16'h8000, 1'b0);
    send_beat(OP_LOAD, 4'd0, 6'd1, 16'h7FFF, 1'b1);
    send_feature(16'h8000, 1'b1);
    wait_drained();

    // Random vectors with stray loads; a few run to full length or beyond
    rand_start = beats_sent;
    vectors    = 0;
    while (beats_sent - rand_start < 750) begin
      repeat ($urandom_range(0, 2)) begin
        send_random_load();
        maybe_idle(beats_sent - rand_start);
      end
      if (vectors == 2) len = DIM;
      else if (vectors == 4) len = DIM + 3;
      else begin
        case ($urandom_range(0, 19))
          18, 19:  len = $urandom_range(DIM + 1, DIM + 8);
          14, 15, 16, 17: len = $urandom_range(9, DIM);
          default: len = $urandom_range(1, 8);
        endcase
      end
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) send_random_load();
        send_feature(rand_value(), i == len - 1);
        maybe_idle(beats_sent - rand_start);
      end
      vectors++;
      if (vectors == 20) wait_drained();
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.pending.size() != 0)
      $display("%0t: %0d signatures never arrived", $time, sb.pending.size());
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
